// ----- hdl/fat_boot_sector_classifier_defines.svh -----
// Assertion macros shared by the classifier RTL.
// Each macro takes a label, a clock, a reset, an antecedent and a consequent.
`ifndef FAT_BOOT_SECTOR_CLASSIFIER_DEFINES_SVH
`define FAT_BOOT_SECTOR_CLASSIFIER_DEFINES_SVH

`ifndef SYNTHESIS
`define FBSC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fbsc same-cycle check failed");
`define FBSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fbsc next-cycle check failed");
`else
`define FBSC_ASSERT_SAME(label, clk, rst, ante, cons)
`define FBSC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- hdl/fbsc_pkg.sv -----
`default_nettype none

package fbsc_pkg;

   localparam logic [15:0] MIN_SECTOR    = 16'd512;
   localparam logic [15:0] MAX_SECTOR    = 16'd4096;
   localparam logic [7:0]  MAX_CLUSTER   = 8'd128;
   localparam logic [31:0] FAT12_LIMIT   = 32'd4085;
   localparam logic [31:0] FAT16_LIMIT   = 32'd65525;
   localparam logic [31:0] FIRST_CLUSTER = 32'd2;
   localparam logic [31:0] MIN_TOTAL     = 32'd5;
   localparam logic [24:0] MIN_ROOT_START = 25'd3;
   localparam int          DIR_ENTRY_SHIFT = 5;

   typedef enum logic [1:0] {
      KIND_INVALID = 2'd0,
      KIND_FAT12   = 2'd1,
      KIND_FAT16   = 2'd2,
      KIND_FAT32   = 2'd3
   } kind_type;

   typedef struct packed {
      logic [15:0] bytes_per_sector;
      logic [7:0]  sectors_per_cluster;
      logic [15:0] reserved_sector_count;
      logic [7:0]  table_copies;
      logic [15:0] root_entry_count;
      logic [15:0] short_total_sectors;
      logic [15:0] short_table_size;
      logic [31:0] long_total_sectors;
      logic [31:0] long_table_size;
      logic [15:0] fs_version;
      logic [31:0] root_start_cluster;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]  volume_kind;
      logic        block_valid;
      logic [31:0] table_size;
      logic [31:0] volume_sectors;
      logic [12:0] root_dir_sector_count;
      logic [31:0] root_dir_first_sector;
      logic [31:0] data_first_sector;
   } rsp_payload_type;

   // Checks settled at decode and carried down the pipe
   typedef struct packed {
      logic       bps_ok;
      logic       spc_ok;
      logic       fat32_ok;
      logic       short_ok;
      logic       base_ok;
      logic [2:0] spc_shift;
   } chk_type;

   typedef struct packed {
      chk_type     chk;
      logic [12:0] rds;
      logic [31:0] tsz;
      logic [31:0] tot;
      logic [31:0] table_prod;
      logic [31:0] root_off;
      logic [23:0] short_prod;
      logic [15:0] rsv;
   } dec_type;

   typedef struct packed {
      chk_type     chk;
      logic        rstart_ok;
      logic [12:0] rds;
      logic [31:0] tsz;
      logic [31:0] tot;
      logic [31:0] fnt;
      logic [31:0] root_off;
   } sum_type;

   typedef struct packed {
      chk_type     chk;
      logic        rstart_ok;
      logic [12:0] rds;
      logic [31:0] tsz;
      logic [31:0] tot;
      logic [31:0] fnt;
      logic [31:0] data_first;
      logic [31:0] root32;
   } addr_type;

endpackage

`default_nettype wire

// ----- hdl/fbsc_if.sv -----
`default_nettype none

interface fbsc_req_if;
   import fbsc_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface fbsc_rsp_if;
   import fbsc_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- hdl/fbsc_decode.sv -----
`default_nettype none

module fbsc_decode (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   output logic                          in_ready,
   input  wire fbsc_pkg::req_payload_type in_data,
   output logic                          out_valid,
   input  wire logic                     out_ready,
   output fbsc_pkg::dec_type             out_data
);
   import fbsc_pkg::*;

   logic        valid_ff;
   dec_type     data_ff;
   dec_type     data_in;
   logic        load;
   logic [21:0] dir_bytes;
   logic [15:0] bps;
   logic [7:0]  spc;

   assign bps = in_data.bytes_per_sector;
   assign spc = in_data.sectors_per_cluster;

   // Size and type checks, root directory sectors, table selects and products
   always_comb begin
      data_in = '0;
      data_in.chk.bps_ok = (bps >= MIN_SECTOR) && (bps <= MAX_SECTOR) &&
                           ((bps & (bps - 16'd1)) == 16'd0);
      data_in.chk.spc_ok = (spc != 8'd0) && (spc <= MAX_CLUSTER) &&
                           ((spc & (spc - 8'd1)) == 8'd0);
      for (int i = 0; i < 8; i++) begin
         if (spc[i]) begin
            data_in.chk.spc_shift = 3'(i);
         end
      end

      // Round the directory byte count up to whole sectors
      dir_bytes = {1'b0, in_data.root_entry_count, 5'd0} + 22'(bps - 16'd1);
      if (data_in.chk.bps_ok) begin
         case (bps[12:9])
            4'b0001: data_in.rds = 13'(dir_bytes >> 9);
            4'b0010: data_in.rds = 13'(dir_bytes >> 10);
            4'b0100: data_in.rds = 13'(dir_bytes >> 11);
            4'b1000: data_in.rds = 13'(dir_bytes >> 12);
            default: data_in.rds = 13'd0;
         endcase
      end

      data_in.tsz = (in_data.short_table_size != 16'd0) ?
                    32'(in_data.short_table_size) : in_data.long_table_size;
      data_in.tot = (in_data.short_total_sectors != 16'd0) ?
                    32'(in_data.short_total_sectors) : in_data.long_total_sectors;
      data_in.table_prod = 32'(32'(in_data.table_copies) * data_in.tsz);
      data_in.root_off   = 32'((in_data.root_start_cluster - FIRST_CLUSTER) *
                               32'(spc));
      data_in.short_prod = 24'(in_data.short_table_size) * 24'(in_data.table_copies);
      data_in.rsv        = in_data.reserved_sector_count;

      data_in.chk.base_ok  = (in_data.reserved_sector_count != 16'd0) &&
                             (in_data.table_copies != 8'd0);
      data_in.chk.fat32_ok = (in_data.fs_version == 16'd0) &&
                             (in_data.short_table_size == 16'd0) &&
                             (in_data.long_table_size != 32'd0) &&
                             (in_data.root_start_cluster >= FIRST_CLUSTER) &&
                             (in_data.short_total_sectors == 16'd0) &&
                             (in_data.long_total_sectors >= MIN_TOTAL) &&
                             (in_data.root_entry_count == 16'd0);
      data_in.chk.short_ok = !((in_data.short_total_sectors != 16'd0) &&
                               (in_data.long_total_sectors != 32'd0)) &&
                             (in_data.short_table_size != 16'd0) &&
                             (in_data.root_entry_count != 16'd0) &&
                             ((32'(in_data.short_total_sectors) >= MIN_TOTAL) ||
                              (in_data.long_total_sectors >= MIN_TOTAL));
   end

   // Advance when the stage is empty or its beat moves on
   assign load     = !valid_ff || out_ready;
   assign in_ready = load;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// ----- hdl/fbsc_layout.sv -----
`default_nettype none

module fbsc_layout (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire fbsc_pkg::dec_type in_data,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output fbsc_pkg::addr_type     out_data
);
   import fbsc_pkg::*;

   logic     sum_valid_ff;
   sum_type  sum_ff;
   sum_type  sum_in;
   logic     sum_load;
   logic     addr_valid_ff;
   addr_type addr_ff;
   addr_type addr_in;
   logic     addr_load;

   // First sector past the tables, and the short-table root start check
   always_comb begin
      sum_in.chk       = in_data.chk;
      sum_in.rds       = in_data.rds;
      sum_in.tsz       = in_data.tsz;
      sum_in.tot       = in_data.tot;
      sum_in.root_off  = in_data.root_off;
      sum_in.fnt       = 32'(in_data.rsv) + in_data.table_prod;
      sum_in.rstart_ok = (25'(in_data.rsv) + 25'(in_data.short_prod)) >= MIN_ROOT_START;
   end

   // Data area start and the FAT32 root start
   always_comb begin
      addr_in.chk        = sum_ff.chk;
      addr_in.rstart_ok  = sum_ff.rstart_ok;
      addr_in.rds        = sum_ff.rds;
      addr_in.tsz        = sum_ff.tsz;
      addr_in.tot        = sum_ff.tot;
      addr_in.fnt        = sum_ff.fnt;
      addr_in.data_first = sum_ff.fnt + 32'(sum_ff.rds);
      addr_in.root32     = sum_ff.fnt + sum_ff.root_off;
   end

   // Each stage advances when empty or when its beat moves on
   assign addr_load = !addr_valid_ff || out_ready;
   assign sum_load  = !sum_valid_ff || addr_load;
   assign in_ready  = sum_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff  <= 1'b0;
         addr_valid_ff <= 1'b0;
      end else begin
         if (sum_load) begin
            sum_valid_ff <= in_valid;
         end
         if (addr_load) begin
            addr_valid_ff <= sum_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (sum_load && in_valid) begin
         sum_ff <= sum_in;
      end
      if (addr_load && sum_valid_ff) begin
         addr_ff <= addr_in;
      end
   end

   assign out_valid = addr_valid_ff;
   assign out_data  = addr_ff;

endmodule

`default_nettype wire

// ----- hdl/fbsc_classify.sv -----
`default_nettype none

module fbsc_classify (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire fbsc_pkg::addr_type in_data,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output fbsc_pkg::rsp_payload_type out_data
);
   import fbsc_pkg::*;

   logic            valid_ff;
   rsp_payload_type data_ff;
   rsp_payload_type data_in;
   logic            load;
   logic [31:0]     data_sectors;
   logic [31:0]     clusters;
   kind_type        kind;
   logic            type_ok;

   // Count clusters, pick the type and apply the type rules
   always_comb begin
      data_sectors = in_data.tot - in_data.data_first;
      clusters     = data_sectors >> in_data.chk.spc_shift;
      if (!(in_data.chk.bps_ok && in_data.chk.spc_ok)) begin
         kind = KIND_INVALID;
      end else if (clusters < FAT12_LIMIT) begin
         kind = KIND_FAT12;
      end else if (clusters < FAT16_LIMIT) begin
         kind = KIND_FAT16;
      end else begin
         kind = KIND_FAT32;
      end

      case (kind)
         KIND_INVALID: type_ok = 1'b0;
         KIND_FAT32:   type_ok = in_data.chk.fat32_ok;
         default:      type_ok = in_data.chk.short_ok && in_data.rstart_ok;
      endcase

      data_in.volume_kind           = kind;
      data_in.block_valid           = type_ok && in_data.chk.base_ok;
      data_in.table_size            = in_data.tsz;
      data_in.volume_sectors        = in_data.tot;
      data_in.root_dir_sector_count = in_data.rds;
      data_in.root_dir_first_sector = (kind == KIND_FAT32) ? in_data.root32 : in_data.fnt;
      data_in.data_first_sector     = in_data.data_first;
   end

   // Output register: take a new beat while empty or while the old one leaves
   assign load     = !valid_ff || out_ready;
   assign in_ready = load;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// ----- hdl/fat_boot_sector_classifier.sv -----
// FAT boot sector classifier.
// req_bus carries one parsed parameter block per beat; rsp_bus returns one
// result per block, in order: volume kind, validity and layout sectors.
// Both channels use valid/ready; a beat moves when both are high.
// The request passes four registers: decode with the root offset, table
// and short-table products, table sum, address sums, classify into the
// output register. One block per cycle while rsp_bus.ready stays high.
// Each of the four stages holds its own valid bit and loads when it is
// empty or its beat moves on, so bubbles close up under backpressure.
// When the receiver stalls, the output register holds its result and the
// pipe keeps taking blocks until all four stages are full; req_bus.ready
// then drops until rsp_bus.ready returns.
// Synchronous reset clears every stage valid bit; nothing else needs it and
// the block is ready in the cycle after reset is released.
`default_nettype none
`include "fat_boot_sector_classifier_defines.svh"

module fat_boot_sector_classifier (
   input  wire logic clock,
   input  wire logic reset,
   fbsc_req_if.sink  req_bus,
   fbsc_rsp_if.source rsp_bus
);
   import fbsc_pkg::*;

   dec_type  dec_data;
   logic     dec_valid;
   logic     dec_ready;
   addr_type addr_data;
   logic     addr_valid;
   logic     addr_ready;

   fbsc_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .in_data   (req_bus.payload),
      .out_valid (dec_valid),
      .out_ready (dec_ready),
      .out_data  (dec_data)
   );

   fbsc_layout u_layout (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dec_valid),
      .in_ready  (dec_ready),
      .in_data   (dec_data),
      .out_valid (addr_valid),
      .out_ready (addr_ready),
      .out_data  (addr_data)
   );

   fbsc_classify u_classify (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (addr_valid),
      .in_ready  (addr_ready),
      .in_data   (addr_data),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_data  (rsp_bus.payload)
   );

   // A valid block always has a kind
   `FBSC_ASSERT_SAME(a_valid_has_kind, clock, reset,
      rsp_bus.valid && rsp_bus.payload.block_valid,
      rsp_bus.payload.volume_kind != KIND_INVALID)

   // Outside FAT32 the data area follows the root directory directly
   `FBSC_ASSERT_SAME(a_root_data_gap, clock, reset,
      rsp_bus.valid && (rsp_bus.payload.volume_kind != KIND_FAT32),
      rsp_bus.payload.data_first_sector ==
      rsp_bus.payload.root_dir_first_sector + 32'(rsp_bus.payload.root_dir_sector_count))

   // Input backpressure only comes from a stalled, full output
   `FBSC_ASSERT_SAME(a_stall_source, clock, reset,
      !req_bus.ready, rsp_bus.valid && !rsp_bus.ready)

   // A stalled result holds its beat until it is taken
   `FBSC_ASSERT_NEXT(a_stall_holds_beat, clock, reset,
      rsp_bus.valid && !rsp_bus.ready,
      rsp_bus.valid && $stable(rsp_bus.payload))

endmodule

`default_nettype wire
